// File: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, codes and color tables of the led strip pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   localparam int unsigned MAX_PIXELS_DEF = 64;
   localparam int unsigned QUEUE_DEPTH    = 2;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned CSR_DATA_W     = 16;
   localparam int unsigned STEP_W         = 10;

   typedef enum logic [2:0] {
      MODE_SOLID,
      MODE_BLINK,
      MODE_SIGNAL,
      MODE_RACE,
      MODE_BOUNCE,
      MODE_SPLIT,
      MODE_BREATHE,
      MODE_RAINBOW
   } lpg_mode_type;

   typedef enum logic [2:0] {
      COLOR_RED,
      COLOR_ORANGE,
      COLOR_YELLOW,
      COLOR_GREEN,
      COLOR_BLUE,
      COLOR_VIOLET,
      COLOR_WHITE,
      COLOR_BLACK
   } lpg_color_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLOR_CODE,
      CSR_PATTERN_MODE,
      CSR_FAST_SPEED,
      CSR_STRIP_LENGTH,
      CSR_SLOW_PERIOD,
      CSR_FAST_PERIOD,
      CSR_BLINK_LIMIT
   } lpg_csr_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] white;
   } lpg_rgbw_type;

   // one update tick after the front has stepped the pattern
   typedef struct packed {
      lpg_mode_type              mode;
      lpg_color_type             color;
      logic signed [STEP_W-1:0]  step;
      logic                      phase;
      logic [6:0]                len;
   } lpg_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lpg_q_stat_type;

   function automatic lpg_rgbw_type palette(input lpg_color_type c);
      lpg_rgbw_type v;
      unique case (c)
         COLOR_RED:    v = '{8'd255, 8'd0,   8'd0,   8'd0};
         COLOR_ORANGE: v = '{8'd255, 8'd32,  8'd0,   8'd0};
         COLOR_YELLOW: v = '{8'd255, 8'd128, 8'd0,   8'd0};
         COLOR_GREEN:  v = '{8'd0,   8'd255, 8'd0,   8'd0};
         COLOR_BLUE:   v = '{8'd0,   8'd0,   8'd255, 8'd0};
         COLOR_VIOLET: v = '{8'd255, 8'd0,   8'd255, 8'd0};
         COLOR_WHITE:  v = '{8'd0,   8'd0,   8'd0,   8'd255};
         COLOR_BLACK:  v = '{8'd0,   8'd0,   8'd0,   8'd0};
      endcase
      return v;
   endfunction

   // color wheel
   function automatic lpg_rgbw_type hue(input logic [7:0] pos);
      lpg_rgbw_type v;
      logic [7:0]   p;
      logic [7:0]   q;
      logic [9:0]   m;
      p = 8'd255 - pos;
      if (p < 8'd85) begin
         q = p;
      end else if (p < 8'd170) begin
         q = p - 8'd85;
      end else begin
         q = p - 8'd170;
      end
      m = {2'b00, q} * 10'd3;
      if (p < 8'd85) begin
         v = '{8'd255 - m[7:0], 8'd0, m[7:0], 8'd0};
      end else if (p < 8'd170) begin
         v = '{8'd0, m[7:0], 8'd255 - m[7:0], 8'd0};
      end else begin
         v = '{m[7:0], 8'd255 - m[7:0], 8'd0, 8'd0};
      end
      return v;
   endfunction

   // x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] y;
      y = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return y[15:8];
   endfunction

endpackage

`default_nettype wire

// File: sv/lpg_if.sv
// ----------------------------------------------------------------------------
// lpg_req_if / lpg_rsp_if
// Valid/ready channels of the led strip pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface lpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] white;
   logic       last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output white, output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input white, input last_pixel, output ready);
endinterface

`default_nettype wire

// File: sv/led_strip_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Steps an LED strip pattern on each time tick and emits one RGBW word per
// pixel of the strip.
//
//   channel   dir   word                                   handshake
//   req_chan  in    now_ms                                 valid/ready
//   rsp_chan  out   pixel_index, red/green/blue/white,     valid/ready
//                   last_pixel
//   csr_*     in    csr_index, csr_wdata                   csr_we, no wait
//
// The front steps the pattern once per accepted tick and can run two ticks
// ahead through the queue. Per tick the back loads the descriptor, sets up,
// then emits one pixel per cycle unless rsp_chan stalls; rainbow first runs
// the bit-serial 256 / strip_length divider. A stalled rsp_chan holds the
// current pixel and the back waits. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_pattern_generator #(
   parameter int unsigned MAX_PIXELS = lpg_pkg::MAX_PIXELS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   lpg_req_if.sink                           req_chan,
   lpg_rsp_if.source                         rsp_chan,
   input  wire                               csr_we,
   input  wire [lpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [lpg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                     push;
   logic                     pop;
   lpg_pkg::lpg_desc_type    push_data;
   lpg_pkg::lpg_desc_type    pop_data;
   lpg_pkg::lpg_q_stat_type  q_stat;

   lpg_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (push),
      .q_data    (push_data)
   );

   lpg_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   lpg_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_data (pop_data),
      .q_stat (q_stat),
      .q_pop  (pop),
      .rsp    (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.len >= 7'd1 && push_data.len <= 7'(MAX_PIXELS)))
      else $error("tick pushed with strip length out of range");

   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.step >= -10'sd1 && push_data.step <= 10'sd256))
      else $error("tick pushed with step count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (push && q_stat.empty) |=> !q_stat.empty)
      else $error("queue lost a tick pushed while empty");

endmodule

`default_nettype wire

// File: sv/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front
// Holds the control registers and pattern state; steps the pattern once per
// accepted tick and pushes a tick descriptor into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_front #(
   parameter int unsigned MAX_PIXELS = lpg_pkg::MAX_PIXELS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   lpg_req_if.sink                            req,
   input  wire                                csr_we,
   input  wire [lpg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [lpg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  lpg_pkg::lpg_q_stat_type            q_stat,
   output logic                               q_push,
   output lpg_pkg::lpg_desc_type              q_data
);

   localparam int unsigned SW = lpg_pkg::STEP_W;

   lpg_pkg::lpg_color_type  working_color_ff, working_color_in;
   lpg_pkg::lpg_mode_type   working_mode_ff, working_mode_in;
   lpg_pkg::lpg_mode_type   prev_mode_ff, prev_mode_in;
   logic signed [SW-1:0]    step_ff, step_in;
   logic                    phase_ff, phase_in;
   logic [31:0]             due_ff, due_in;
   logic                    fast_speed_ff, fast_speed_in;
   logic [6:0]              strip_len_ff, strip_len_in;
   logic [15:0]             slow_period_ff, slow_period_in;
   logic [15:0]             fast_period_ff, fast_period_in;
   logic [7:0]              blink_limit_ff, blink_limit_in;

   logic                    accept;
   logic                    mode_chg;
   logic signed [SW-1:0]    s0, s_inc, s_n;
   logic                    p0, p_n;
   logic [31:0]             d0, due_n;
   logic [6:0]              len_c;
   logic signed [SW-1:0]    len_s, half_s, blink_s;
   logic                    is_sig, adv;
   logic [15:0]             period;
   lpg_pkg::lpg_color_type  wc_n;
   lpg_pkg::lpg_mode_type   wm_n;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && !q_stat.full;

   always_comb begin
      mode_chg = working_mode_ff != prev_mode_ff;
      s0       = mode_chg ? -SW'(1) : step_ff;
      p0       = mode_chg ? 1'b0 : phase_ff;
      d0       = mode_chg ? 32'd0 : due_ff;

      len_c = strip_len_ff;
      if (len_c == 7'd0) begin
         len_c = 7'd1;
      end
      if (len_c > 7'(MAX_PIXELS)) begin
         len_c = 7'(MAX_PIXELS);
      end
      len_s   = $signed({3'b000, len_c});
      half_s  = $signed({4'b0000, len_c[6:1]});
      blink_s = $signed({2'b00, blink_limit_ff});

      is_sig = working_mode_ff == lpg_pkg::MODE_SIGNAL;
      period = (fast_speed_ff || is_sig) ? fast_period_ff : slow_period_ff;
      adv    = (working_mode_ff != lpg_pkg::MODE_SOLID) && (req.now_ms > d0);
      due_n  = adv ? req.now_ms + {16'd0, period} : d0;
      s_inc  = s0 + $signed({{(SW-1){1'b0}}, adv});

      s_n  = s_inc;
      p_n  = p0;
      wc_n = working_color_ff;
      wm_n = working_mode_ff;
      unique case (working_mode_ff) inside
         lpg_pkg::MODE_SOLID: begin
            s_n = '0;
         end
         lpg_pkg::MODE_BLINK, lpg_pkg::MODE_SIGNAL: begin
            p_n = p0 ^ adv;
            s_n = s0 + $signed({{(SW-1){1'b0}}, is_sig & adv & p_n});
            // signal run is over: back to solid black
            if (s_n > blink_s) begin
               p_n  = 1'b0;
               s_n  = '0;
               wc_n = lpg_pkg::COLOR_BLACK;
               wm_n = lpg_pkg::MODE_SOLID;
            end
         end
         lpg_pkg::MODE_RACE: begin
            if (s_inc >= len_s) begin
               s_n = '0;
            end
         end
         lpg_pkg::MODE_BOUNCE: begin
            if (s_inc >= len_s) begin
               s_n = '0;
               p_n = ~p0;
            end
         end
         lpg_pkg::MODE_SPLIT: begin
            if (len_c[0] ? (s_inc > half_s) : (s_inc >= half_s)) begin
               s_n = '0;
            end
         end
         lpg_pkg::MODE_BREATHE: begin
            if (s_inc >= SW'(255)) begin
               s_n = '0;
               p_n = ~p0;
            end
         end
         lpg_pkg::MODE_RAINBOW: begin
            if (s_inc >= SW'(255)) begin
               s_n = '0;
            end
         end
      endcase
   end

   assign q_push       = accept;
   assign q_data.mode  = working_mode_ff;
   assign q_data.color = working_color_ff;
   assign q_data.step  = s_n;
   assign q_data.phase = p_n;
   assign q_data.len   = len_c;

   always_comb begin
      working_color_in = working_color_ff;
      working_mode_in  = working_mode_ff;
      prev_mode_in     = prev_mode_ff;
      step_in          = step_ff;
      phase_in         = phase_ff;
      due_in           = due_ff;
      fast_speed_in    = fast_speed_ff;
      strip_len_in     = strip_len_ff;
      slow_period_in   = slow_period_ff;
      fast_period_in   = fast_period_ff;
      blink_limit_in   = blink_limit_ff;

      if (accept) begin
         prev_mode_in     = working_mode_ff;
         step_in          = s_n;
         phase_in         = p_n;
         due_in           = due_n;
         working_color_in = wc_n;
         working_mode_in  = wm_n;
      end

      if (csr_we) begin
         unique case (lpg_pkg::lpg_csr_type'(csr_index))
            lpg_pkg::CSR_COLOR_CODE:
               working_color_in = lpg_pkg::lpg_color_type'(csr_wdata[2:0]);
            lpg_pkg::CSR_PATTERN_MODE:
               working_mode_in = lpg_pkg::lpg_mode_type'(csr_wdata[2:0]);
            lpg_pkg::CSR_FAST_SPEED:   fast_speed_in  = csr_wdata[0];
            lpg_pkg::CSR_STRIP_LENGTH: strip_len_in   = csr_wdata[6:0];
            lpg_pkg::CSR_SLOW_PERIOD:  slow_period_in = csr_wdata[15:0];
            lpg_pkg::CSR_FAST_PERIOD:  fast_period_in = csr_wdata[15:0];
            lpg_pkg::CSR_BLINK_LIMIT:  blink_limit_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         working_color_ff <= lpg_pkg::COLOR_BLACK;
         working_mode_ff  <= lpg_pkg::MODE_SOLID;
         prev_mode_ff     <= lpg_pkg::MODE_SOLID;
         step_ff          <= -SW'(1);
         phase_ff         <= 1'b0;
         due_ff           <= 32'd0;
         fast_speed_ff    <= 1'b0;
         strip_len_ff     <= 7'd64;
         slow_period_ff   <= 16'd500;
         fast_period_ff   <= 16'd100;
         blink_limit_ff   <= 8'd3;
      end else begin
         working_color_ff <= working_color_in;
         working_mode_ff  <= working_mode_in;
         prev_mode_ff     <= prev_mode_in;
         step_ff          <= step_in;
         phase_ff         <= phase_in;
         due_ff           <= due_in;
         fast_speed_ff    <= fast_speed_in;
         strip_len_ff     <= strip_len_in;
         slow_period_ff   <= slow_period_in;
         fast_period_ff   <= fast_period_in;
         blink_limit_ff   <= blink_limit_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/lpg_fifo.sv
// ----------------------------------------------------------------------------
// lpg_fifo
// Short queue of tick descriptors between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_fifo (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  lpg_pkg::lpg_desc_type     push_data,
   input  wire                       pop,
   output lpg_pkg::lpg_desc_type     pop_data,
   output lpg_pkg::lpg_q_stat_type   stat
);

   localparam int unsigned DEPTH = lpg_pkg::QUEUE_DEPTH;
   localparam int unsigned AW    = $clog2(DEPTH);

   lpg_pkg::lpg_desc_type  mem_ff [DEPTH];
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW:0]            count_ff, count_in;

   assign stat.full  = count_ff == (AW+1)'(DEPTH);
   assign stat.empty = count_ff == '0;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back
// Renders one queued tick into per-pixel RGBW words, one pixel per cycle
// while rsp is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_back (
   input  wire                       clock,
   input  wire                       reset,
   input  lpg_pkg::lpg_desc_type     q_data,
   input  lpg_pkg::lpg_q_stat_type   q_stat,
   output logic                      q_pop,
   lpg_rsp_if.source                 rsp
);

   localparam int unsigned SW        = lpg_pkg::STEP_W;
   localparam int unsigned DIV_STEPS = 9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_RUN
   } state_type;

   state_type               state_ff, state_in;
   lpg_pkg::lpg_desc_type   desc_ff, desc_in;
   lpg_pkg::lpg_rgbw_type   col_ff, col_in;
   logic                    dark_ff, dark_in;
   logic [15:0]             prod_ff [4];
   logic [15:0]             prod_in [4];
   logic signed [SW-1:0]    pos_a_ff, pos_a_in;
   logic signed [SW-1:0]    pos_b_ff, pos_b_in;
   logic [8:0]              num_ff, num_in;
   logic [8:0]              quot_ff, quot_in;
   logic [6:0]              rem_ff, rem_in;
   logic [3:0]              dcnt_ff, dcnt_in;
   logic [8:0]              qacc_ff, qacc_in;
   logic [6:0]              racc_ff, racc_in;
   logic [5:0]              idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lpg_pkg::lpg_rgbw_type   pix_ff, pix_in;
   logic [5:0]              pidx_ff, pidx_in;
   logic                    last_ff, last_in;

   lpg_pkg::lpg_rgbw_type   col_c, pix_c;
   logic signed [SW-1:0]    st, len_s, half_s, idx_s;
   logic signed [SW:0]      lvl;
   logic [7:0]              level;
   logic [7:0]              trial;
   logic                    ge;
   logic [7:0]              rsum;
   logic                    lit, is_last, out_free;
   logic [7:0]              hpos;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_index = pidx_ff;
   assign rsp.red         = pix_ff.red;
   assign rsp.green       = pix_ff.green;
   assign rsp.blue        = pix_ff.blue;
   assign rsp.white       = pix_ff.white;
   assign rsp.last_pixel  = last_ff;

   always_comb begin
      st     = desc_ff.step;
      len_s  = $signed({3'b000, desc_ff.len});
      half_s = $signed({4'b0000, desc_ff.len[6:1]});
      idx_s  = $signed({4'b0000, idx_ff});
      col_c  = lpg_pkg::palette(desc_ff.color);

      // breathe level, clamped
      lvl = desc_ff.phase ? ((SW+1)'(255) - (SW+1)'(st)) : (SW+1)'(st);
      if (lvl < 0) begin
         level = 8'd0;
      end else if (lvl > (SW+1)'(255)) begin
         level = 8'd255;
      end else begin
         level = lvl[7:0];
      end

      trial    = {rem_ff, num_ff[8]};
      ge       = trial >= {1'b0, desc_ff.len};
      rsum     = {1'b0, racc_ff} + {1'b0, rem_ff};
      lit      = (pos_a_ff == idx_s) || (pos_b_ff == idx_s);
      is_last  = {1'b0, idx_ff} == (desc_ff.len - 7'd1);
      out_free = !rsp_valid_ff || rsp.ready;
      hpos     = qacc_ff[7:0] + st[7:0];

      unique case (desc_ff.mode) inside
         lpg_pkg::MODE_SOLID, lpg_pkg::MODE_BLINK, lpg_pkg::MODE_SIGNAL:
            pix_c = dark_ff ? '0 : col_ff;
         lpg_pkg::MODE_RACE, lpg_pkg::MODE_BOUNCE, lpg_pkg::MODE_SPLIT:
            pix_c = lit ? col_ff : '0;
         lpg_pkg::MODE_BREATHE:
            pix_c = '{lpg_pkg::div255(prod_ff[0]), lpg_pkg::div255(prod_ff[1]),
                      lpg_pkg::div255(prod_ff[2]), lpg_pkg::div255(prod_ff[3])};
         lpg_pkg::MODE_RAINBOW:
            pix_c = lpg_pkg::hue(hpos);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      col_in       = col_ff;
      dark_in      = dark_ff;
      prod_in      = prod_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      qacc_in      = qacc_ff;
      racc_in      = racc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pix_in       = pix_ff;
      pidx_in      = pidx_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               desc_in  = q_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            col_in     = col_c;
            dark_in    = ((desc_ff.mode == lpg_pkg::MODE_BLINK) ||
                          (desc_ff.mode == lpg_pkg::MODE_SIGNAL)) && !desc_ff.phase;
            prod_in[0] = {8'd0, col_c.red}   * {8'd0, level};
            prod_in[1] = {8'd0, col_c.green} * {8'd0, level};
            prod_in[2] = {8'd0, col_c.blue}  * {8'd0, level};
            prod_in[3] = {8'd0, col_c.white} * {8'd0, level};
            pos_a_in   = -SW'(1);
            pos_b_in   = -SW'(1);
            case (desc_ff.mode)
               lpg_pkg::MODE_RACE: begin
                  pos_a_in = st;
                  pos_b_in = st;
               end
               lpg_pkg::MODE_BOUNCE: begin
                  pos_a_in = desc_ff.phase ? (len_s - SW'(1) - st) : st;
                  pos_b_in = pos_a_in;
               end
               lpg_pkg::MODE_SPLIT: begin
                  if (desc_ff.len[0]) begin
                     pos_a_in = half_s + st;
                     pos_b_in = half_s - st;
                  end else begin
                     pos_a_in = half_s - st - SW'(1);
                     pos_b_in = half_s + st;
                  end
               end
               default: ;
            endcase
            num_in   = 9'h100;
            quot_in  = '0;
            rem_in   = '0;
            dcnt_in  = '0;
            qacc_in  = '0;
            racc_in  = '0;
            idx_in   = '0;
            state_in = (desc_ff.mode == lpg_pkg::MODE_RAINBOW) ? ST_DIVIDE : ST_RUN;
         end
         ST_DIVIDE: begin
            // 256 / len, one quotient bit per cycle
            rem_in  = ge ? 7'(trial - {1'b0, desc_ff.len}) : trial[6:0];
            quot_in = {quot_ff[7:0], ge};
            num_in  = {num_ff[7:0], 1'b0};
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(DIV_STEPS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pix_in       = pix_c;
               pidx_in      = idx_ff;
               last_in      = is_last;
               idx_in       = idx_ff + 6'd1;
               // step i*256/len by quotient and remainder of 256/len
               if (rsum >= {1'b0, desc_ff.len}) begin
                  racc_in = 7'(rsum - {1'b0, desc_ff.len});
                  qacc_in = qacc_ff + quot_ff + 9'd1;
               end else begin
                  racc_in = rsum[6:0];
                  qacc_in = qacc_ff + quot_ff;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff  <= desc_in;
      col_ff   <= col_in;
      dark_ff  <= dark_in;
      prod_ff  <= prod_in;
      pos_a_ff <= pos_a_in;
      pos_b_ff <= pos_b_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      qacc_ff  <= qacc_in;
      racc_ff  <= racc_in;
      idx_ff   <= idx_in;
      pix_ff   <= pix_in;
      pidx_ff  <= pidx_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire
